[hdl/rqm_pkg.sv]
// Shared types and constants for the result quota monitor.
package rqm_pkg;

   localparam int unsigned RowWidth = 32;
   localparam int unsigned ByteWidth = 48;
   localparam int unsigned SizeWidth = 32;
   localparam int unsigned CsrAddrWidth = 6;
   localparam int unsigned CsrDataWidth = 64;
   localparam int unsigned CsrIndexLsb = 3;

   typedef enum logic [1:0] {
      CMD_OBSERVE = 2'd0,
      CMD_CHECK   = 2'd1,
      CMD_CLEAR   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EXCEEDED = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      HIT_NONE     = 3'd0,
      HIT_COLUMN   = 3'd1,
      HIT_IDENTITY = 3'd2,
      HIT_ROWS     = 3'd3,
      HIT_BYTES    = 3'd4,
      HIT_QUERY    = 3'd5
   } hit_type;

   typedef enum logic [2:0] {
      REG_MAX_ROWS          = 3'd0,
      REG_MAX_TOTAL_BYTES   = 3'd1,
      REG_MAX_COLUMN_SIZE   = 3'd2,
      REG_MAX_IDENTITY_SIZE = 3'd3,
      REG_MAX_QUERY_SIZE    = 3'd4,
      REG_MAX_PARAM_SIZE    = 3'd5,
      REG_MAX_LIST_VALUES   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [RowWidth-1:0]  max_rows;
      logic [ByteWidth-1:0] max_total_bytes;
      logic [SizeWidth-1:0] max_column_size;
      logic [SizeWidth-1:0] max_identity_size;
      logic [SizeWidth-1:0] max_query_size;
      logic [SizeWidth-1:0] max_param_size;
      logic [SizeWidth-1:0] max_list_values;
   } limits_type;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [SizeWidth-1:0] row_size;
      logic [SizeWidth-1:0] widest_column;
      logic [SizeWidth-1:0] identity_size;
      logic [SizeWidth-1:0] query_size;
      logic [SizeWidth-1:0] param_size;
      logic [SizeWidth-1:0] list_values;
   } item_type;

   typedef struct packed {
      status_type           status;
      hit_type              limit_hit;
      logic [ByteWidth-1:0] observed;
      logic [RowWidth-1:0]  rows_used;
      logic [ByteWidth-1:0] bytes_used;
   } result_type;

endpackage

[hdl/result_quota_monitor.sv]
// Result quota monitor: row and byte counters checked against programmable limits.
// A request is captured in the input register; its result is held in the result register.
// Throughput: one transaction per cycle unless rsp_stall holds a pending result; the counter
// update sits in one pass of logic between the input register and the result register.
// Reset: synchronous; clears both counters and valid flags, and sets every limit to all ones.
module result_quota_monitor (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_cmd,
   input  logic [rqm_pkg::SizeWidth-1:0]         req_row_size,
   input  logic [rqm_pkg::SizeWidth-1:0]         req_widest_column,
   input  logic [rqm_pkg::SizeWidth-1:0]         req_identity_size,
   input  logic [rqm_pkg::SizeWidth-1:0]         req_query_size,
   input  logic [rqm_pkg::SizeWidth-1:0]         req_param_size,
   input  logic [rqm_pkg::SizeWidth-1:0]         req_list_values,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [2:0]                            rsp_limit_hit,
   output logic [rqm_pkg::ByteWidth-1:0]         rsp_observed,
   output logic [rqm_pkg::RowWidth-1:0]          rsp_rows_used,
   output logic [rqm_pkg::ByteWidth-1:0]         rsp_bytes_used,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rqm_pkg::CsrAddrWidth-1:0]      paddr,
   input  logic [rqm_pkg::CsrDataWidth-1:0]      pwdata,
   output logic [rqm_pkg::CsrDataWidth-1:0]      prdata,
   output logic                                  pready
);
   import rqm_pkg::*;

   limits_type           limits;
   item_type             req_item;
   result_type           eval_result;
   logic                 in_valid_ff;
   logic                 in_valid_in;
   item_type             in_item_ff;
   item_type             in_item_in;
   logic [RowWidth-1:0]  row_count_ff;
   logic [RowWidth-1:0]  row_count_in;
   logic [ByteWidth-1:0] byte_total_ff;
   logic [ByteWidth-1:0] byte_total_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   result_type           rsp_data_ff;
   result_type           rsp_data_in;
   logic                 rsp_load;
   logic                 in_load;
   logic                 eval_fire;

   rqm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limits  (limits)
   );

   assign req_item.cmd           = req_cmd;
   assign req_item.row_size      = req_row_size;
   assign req_item.widest_column = req_widest_column;
   assign req_item.identity_size = req_identity_size;
   assign req_item.query_size    = req_query_size;
   assign req_item.param_size    = req_param_size;
   assign req_item.list_values   = req_list_values;

   rqm_eval u_eval (
      .item       (in_item_ff),
      .limits     (limits),
      .row_count  (row_count_ff),
      .byte_total (byte_total_ff),
      .result     (eval_result)
   );

   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign in_load   = !in_valid_ff || rsp_load;
   assign eval_fire = in_valid_ff && rsp_load;
   assign req_stall = !in_load;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_item_in    = in_item_ff;
      row_count_in  = row_count_ff;
      byte_total_in = byte_total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (in_load) begin
         in_valid_in = req_valid;
         in_item_in  = req_item;
      end
      if (rsp_load) begin
         rsp_valid_in = in_valid_ff;
         rsp_data_in  = eval_result;
      end
      if (eval_fire) begin
         row_count_in  = eval_result.rows_used;
         byte_total_in = eval_result.bytes_used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         row_count_ff  <= '0;
         byte_total_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         row_count_ff  <= row_count_in;
         byte_total_ff <= byte_total_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_limit_hit  = rsp_data_ff.limit_hit;
   assign rsp_observed   = rsp_data_ff.observed;
   assign rsp_rows_used  = rsp_data_ff.rows_used;
   assign rsp_bytes_used = rsp_data_ff.bytes_used;

   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      !eval_fire |=> $stable(row_count_ff) && $stable(byte_total_ff))
      else $error("Counters changed without an evaluated transaction.");

   a_overflow_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OVERFLOW |->
         rsp_limit_hit == HIT_NONE && rsp_observed == '0)
      else $error("Overflow result carries a limit report.");

   a_rows_observed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_limit_hit == HIT_ROWS |->
         rsp_observed == {{(ByteWidth-RowWidth){1'b0}}, rsp_rows_used} + 48'd1)
      else $error("Row limit report does not match the row count.");

   a_ok_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_limit_hit == HIT_NONE)
      else $error("Good result reports a tripped limit.");

endmodule

[hdl/rqm_csr.sv]
// Limit register file behind the APB-style configuration port.
module rqm_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rqm_pkg::CsrAddrWidth-1:0]      paddr,
   input  logic [rqm_pkg::CsrDataWidth-1:0]      pwdata,
   output logic [rqm_pkg::CsrDataWidth-1:0]      prdata,
   output logic                                  pready,
   output rqm_pkg::limits_type                   limits
);
   import rqm_pkg::*;

   limits_type    limits_ff;
   limits_type    limits_in;
   reg_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = reg_index_type'(paddr[CsrAddrWidth-1:CsrIndexLsb]);
   assign write_en = psel && penable && pwrite;
   assign limits   = limits_ff;

   always_comb begin
      limits_in = limits_ff;
      if (write_en) begin
         unique case (index)
            REG_MAX_ROWS:          limits_in.max_rows = pwdata[RowWidth-1:0];
            REG_MAX_TOTAL_BYTES:   limits_in.max_total_bytes = pwdata[ByteWidth-1:0];
            REG_MAX_COLUMN_SIZE:   limits_in.max_column_size = pwdata[SizeWidth-1:0];
            REG_MAX_IDENTITY_SIZE: limits_in.max_identity_size = pwdata[SizeWidth-1:0];
            REG_MAX_QUERY_SIZE:    limits_in.max_query_size = pwdata[SizeWidth-1:0];
            REG_MAX_PARAM_SIZE:    limits_in.max_param_size = pwdata[SizeWidth-1:0];
            REG_MAX_LIST_VALUES:   limits_in.max_list_values = pwdata[SizeWidth-1:0];
            default:               limits_in = limits_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_MAX_ROWS:
            prdata = {{(CsrDataWidth-RowWidth){1'b0}}, limits_ff.max_rows};
         REG_MAX_TOTAL_BYTES:
            prdata = {{(CsrDataWidth-ByteWidth){1'b0}}, limits_ff.max_total_bytes};
         REG_MAX_COLUMN_SIZE:
            prdata = {{(CsrDataWidth-SizeWidth){1'b0}}, limits_ff.max_column_size};
         REG_MAX_IDENTITY_SIZE:
            prdata = {{(CsrDataWidth-SizeWidth){1'b0}}, limits_ff.max_identity_size};
         REG_MAX_QUERY_SIZE:
            prdata = {{(CsrDataWidth-SizeWidth){1'b0}}, limits_ff.max_query_size};
         REG_MAX_PARAM_SIZE:
            prdata = {{(CsrDataWidth-SizeWidth){1'b0}}, limits_ff.max_param_size};
         REG_MAX_LIST_VALUES:
            prdata = {{(CsrDataWidth-SizeWidth){1'b0}}, limits_ff.max_list_values};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= '1;
      end else begin
         limits_ff <= limits_in;
      end
   end

endmodule

[hdl/rqm_eval.sv]
// Single-pass evaluation of one transaction against the limits and counters.
module rqm_eval (
   input  rqm_pkg::item_type                     item,
   input  rqm_pkg::limits_type                   limits,
   input  logic [rqm_pkg::RowWidth-1:0]          row_count,
   input  logic [rqm_pkg::ByteWidth-1:0]         byte_total,
   output rqm_pkg::result_type                   result
);
   import rqm_pkg::*;

   logic [ByteWidth:0]   byte_sum;
   logic [RowWidth:0]    row_next;
   logic                 overflow;
   status_type           status;
   hit_type              hit;
   logic [ByteWidth-1:0] observed;
   logic [RowWidth-1:0]  rows_out;
   logic [ByteWidth-1:0] bytes_out;

   assign byte_sum = {1'b0, byte_total} + {{(ByteWidth+1-SizeWidth){1'b0}}, item.row_size};
   assign row_next = {1'b0, row_count} + {{RowWidth{1'b0}}, 1'b1};
   assign overflow = (&row_count) || byte_sum[ByteWidth];

   always_comb begin
      status    = ST_OK;
      hit       = HIT_NONE;
      observed  = '0;
      rows_out  = row_count;
      bytes_out = byte_total;
      unique case (cmd_type'(item.cmd))
         CMD_OBSERVE: begin
            if (overflow) begin
               status = ST_OVERFLOW;
            end else begin
               priority if (item.widest_column > limits.max_column_size) begin
                  hit      = HIT_COLUMN;
                  observed = {{(ByteWidth-SizeWidth){1'b0}}, item.widest_column};
               end else if (item.identity_size > limits.max_identity_size) begin
                  hit      = HIT_IDENTITY;
                  observed = {{(ByteWidth-SizeWidth){1'b0}}, item.identity_size};
               end else if (row_next > {1'b0, limits.max_rows}) begin
                  hit      = HIT_ROWS;
                  observed = {{(ByteWidth-RowWidth-1){1'b0}}, row_next};
               end else if (byte_sum[ByteWidth-1:0] > limits.max_total_bytes) begin
                  hit      = HIT_BYTES;
                  observed = byte_sum[ByteWidth-1:0];
               end else begin
                  rows_out  = row_next[RowWidth-1:0];
                  bytes_out = byte_sum[ByteWidth-1:0];
               end
               if (hit != HIT_NONE) begin
                  status = ST_EXCEEDED;
               end
            end
         end
         CMD_CHECK: begin
            priority if (item.query_size > limits.max_query_size) begin
               status   = ST_EXCEEDED;
               hit      = HIT_QUERY;
               observed = {{(ByteWidth-SizeWidth){1'b0}}, item.query_size};
            end else if (item.param_size > limits.max_param_size) begin
               status   = ST_EXCEEDED;
               hit      = HIT_QUERY;
               observed = {{(ByteWidth-SizeWidth){1'b0}}, item.param_size};
            end else if (item.list_values > limits.max_list_values) begin
               status   = ST_EXCEEDED;
               hit      = HIT_QUERY;
               observed = {{(ByteWidth-SizeWidth){1'b0}}, item.list_values};
            end else begin
               status = ST_OK;
            end
         end
         CMD_CLEAR: begin
            rows_out  = '0;
            bytes_out = '0;
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign result.status     = status;
   assign result.limit_hit  = hit;
   assign result.observed   = observed;
   assign result.rows_used  = rows_out;
   assign result.bytes_used = bytes_out;

endmodule
